[src/m2d_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m2d_pkg
// shared constants and types for the minifloat to double converter
// ----------------------------------------------------------------------------
package m2d_pkg;

   localparam int MAX_WIDTH = 32;
   localparam int WBITS     = 6;
   localparam int EBITS     = 4;
   localparam int FBITS     = 5;   // fraction width up to 29
   localparam int PBITS     = 6;   // clamped width up to 32

   localparam logic [WBITS-1:0] CSR_TOTAL_BITS = 6'd0;
   localparam logic [WBITS-1:0] CSR_EXP_BITS   = 6'd1;

   // decoded format, shared by config and datapath
   typedef struct packed {
      logic [PBITS-1:0] w;
      logic [EBITS-1:0] e_w;
      logic [FBITS-1:0] f_w;
   } fmt_type;

endpackage

[src/minifloat_to_double_converter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minifloat_to_double_converter
// converts a configurable minifloat pattern to an exact binary64 pattern
// ----------------------------------------------------------------------------
// datapath: single pass, in_pat_ff to m2d_conv to out_data_ff
// throughput: one transaction per cycle while rsp_ready is high
// reset: total_bits 8, exp_bits 4, pipeline emptied
module minifloat_to_double_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_pattern,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_double_bits,
   input  logic        csr_write,
   input  logic [5:0]  csr_index,
   input  logic [5:0]  csr_data
);

   m2d_pkg::fmt_type fmt;
   logic        in_valid_ff;
   logic [31:0] in_pat_ff;
   logic        out_valid_ff;
   logic [63:0] out_data_ff;
   logic [63:0] conv_data;
   logic        adv;

   m2d_cfg u_cfg (
      .clock, .reset, .csr_write, .csr_index, .csr_data, .fmt
   );

   m2d_conv u_conv (.fmt, .pattern(in_pat_ff), .double_bits(conv_data));

   // result stage moves when empty or being drained
   assign adv       = !out_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) in_valid_ff <= req_valid;
         if (adv) out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) in_pat_ff <= req_pattern;
      if (adv && in_valid_ff) out_data_ff <= conv_data;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_double_bits = out_data_ff;

endmodule

[src/m2d_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m2d_cfg
// format registers with saturation of width and exponent field size
// ----------------------------------------------------------------------------
module m2d_cfg (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write,
   input  logic [m2d_pkg::WBITS-1:0]    csr_index,
   input  logic [5:0]                   csr_data,
   output m2d_pkg::fmt_type             fmt
);

   logic [5:0] total_ff;
   logic [3:0] exp_ff;
   logic [5:0] w;
   logic [3:0] e_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= 6'd8;
         exp_ff   <= 4'd4;
      end else if (csr_write) begin
         if (csr_index == m2d_pkg::CSR_TOTAL_BITS) total_ff <= csr_data;
         else if (csr_index == m2d_pkg::CSR_EXP_BITS) exp_ff <= csr_data[3:0];
      end
   end

   always_comb begin
      w = total_ff;
      if (w < 6'd4) w = 6'd4;
      if (w > 6'(m2d_pkg::MAX_WIDTH)) w = 6'(m2d_pkg::MAX_WIDTH);
      e_w = exp_ff;
      if (e_w < 4'd2) e_w = 4'd2;
      if (e_w > 4'd8) e_w = 4'd8;
      if ({2'b00, e_w} > w - 6'd1) e_w = 4'(w - 6'd1);
      fmt.w   = w;
      fmt.e_w = e_w;
      fmt.f_w = 5'(w - 6'd1 - {2'b00, e_w});
   end

endmodule

[src/m2d_conv.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m2d_conv
// field split, subnormal normalization and double packing
// ----------------------------------------------------------------------------
module m2d_conv (
   input  m2d_pkg::fmt_type fmt,
   input  logic [31:0]      pattern,
   output logic [63:0]      double_bits
);

   logic [31:0] pat;
   logic        sign;
   logic [7:0]  efield;
   logic [31:0] mfield;
   logic [10:0] bias;
   logic [4:0]  p;
   logic [10:0] bexp;
   logic [51:0] frac;
   logic [63:0] wide;

   always_comb begin
      pat    = (fmt.w == 6'd32) ? pattern : (pattern & ((32'd1 << fmt.w) - 32'd1));
      sign   = pat[5'(fmt.w - 6'd1)];
      efield = 8'((pat >> fmt.f_w) & ((32'd1 << fmt.e_w) - 32'd1));
      mfield = pat & ((32'd1 << fmt.f_w) - 32'd1);
      bias   = (11'd1 << (fmt.e_w - 4'd1)) - 11'd1;
      p = 5'd0;
      for (int i = 0; i < 29; i++) begin
         if (mfield[i]) p = 5'(i);
      end
      wide = 64'd0;
      if (efield != 8'd0) begin
         bexp = 11'd1023 + {3'd0, efield} - bias;
         wide = {32'd0, mfield} << (6'd52 - {1'b0, fmt.f_w});
         frac = wide[51:0];
         double_bits = {sign, bexp, frac};
      end else if (mfield == 32'd0) begin
         bexp = 11'd0;
         frac = 52'd0;
         double_bits = {sign, 63'd0};
      end else begin
         bexp = 11'd1024 + {6'd0, p} - bias - {6'd0, fmt.f_w};
         wide = ({32'd0, mfield} << (6'd52 - {1'b0, p}));
         frac = wide[51:0];
         double_bits = {sign, bexp, frac};
      end
   end

endmodule
